[rtl/core/assert_macros.svh]
// Assertion macros shared by the I2C bus master RTL.
// Depends on nothing; synthesis builds see empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/core/i2cm_pkg.sv]
// Package for the I2C bus master: command and micro-op codes, word types
// and the micro-program table. Depends on nothing.
package i2cm_pkg;

	localparam int PHASE_W = 5;
	typedef logic [PHASE_W-1:0] phase_t;

	localparam phase_t PH_IDLE  = 5'd0;
	localparam phase_t PH_FIRST = 5'd1;

	localparam logic [2:0] FUNC_NONE     = 3'd0;
	localparam logic [2:0] FUNC_START    = 3'd1;
	localparam logic [2:0] FUNC_STOP     = 3'd2;
	localparam logic [2:0] FUNC_WRITE    = 3'd3;
	localparam logic [2:0] FUNC_READ     = 3'd4;
	localparam logic [2:0] FUNC_RECOVER  = 3'd5;
	localparam logic [2:0] FUNC_READ_ACK = 3'd6;

	localparam logic [2:0] PROG_START   = 3'd0;
	localparam logic [2:0] PROG_STOP    = 3'd1;
	localparam logic [2:0] PROG_WRITE   = 3'd2;
	localparam logic [2:0] PROG_READ    = 3'd3;
	localparam logic [2:0] PROG_RECOVER = 3'd4;

	localparam logic [3:0] OP_END     = 4'd0;
	localparam logic [3:0] OP_SDA_REL = 4'd1;
	localparam logic [3:0] OP_SDA_LOW = 4'd2;
	localparam logic [3:0] OP_SDA_BIT = 4'd3;
	localparam logic [3:0] OP_SDA_ACK = 4'd4;
	localparam logic [3:0] OP_SCL_LOW = 4'd5;
	localparam logic [3:0] OP_SCL_REL = 4'd6;
	localparam logic [3:0] OP_FULL    = 4'd7;
	localparam logic [3:0] OP_HALF    = 4'd8;
	localparam logic [3:0] OP_ACK_IN  = 4'd9;
	localparam logic [3:0] OP_BIT_IN  = 4'd10;
	localparam logic [3:0] OP_SHIFT   = 4'd11;
	localparam logic [3:0] OP_COUNT   = 4'd12;
	localparam logic [3:0] OP_LOOP    = 4'd13;
	localparam logic [3:0] OP_RX_OUT  = 4'd14;

	localparam int         CHAIN_STEPS    = 4;
	localparam int         TX_MSB         = 7;
	localparam logic [3:0] BYTE_BITS      = 4'd8;
	localparam logic [3:0] RECOVER_PULSES = 4'd9;

	localparam logic        REG_DELAY_TICKS = 1'b0;
	localparam logic [15:0] DELAY_RESET     = 16'd10;

	typedef struct packed {
		logic [3:0] op;
		logic [4:0] arg;
	} micro_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       scl_in;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

	function automatic micro_t mw(logic [3:0] op, logic [4:0] arg);
		micro_t m;
		m.op  = op;
		m.arg = arg;
		return m;
	endfunction

	function automatic logic [2:0] prog_of(logic [2:0] active_op);
		logic [2:0] p;
		unique case (active_op) inside
			FUNC_START: p = PROG_START;
			FUNC_STOP: p = PROG_STOP;
			FUNC_WRITE: p = PROG_WRITE;
			FUNC_READ, FUNC_READ_ACK: p = PROG_READ;
			default: p = PROG_RECOVER;
		endcase
		return p;
	endfunction

	function automatic micro_t micro_word(logic [2:0] prog, phase_t ph);
		micro_t m;
		m = mw(OP_END, 5'd0);
		unique case (prog)
			PROG_START: begin
				unique case (ph)
					5'd1: m = mw(OP_SDA_REL, 5'd0);
					5'd2: m = mw(OP_SCL_REL, 5'd0);
					5'd3: m = mw(OP_FULL, 5'd0);
					5'd4: m = mw(OP_SDA_LOW, 5'd0);
					5'd5: m = mw(OP_FULL, 5'd0);
					5'd6: m = mw(OP_SCL_LOW, 5'd0);
					default: m = mw(OP_END, 5'd0);
				endcase
			end
			PROG_STOP: begin
				unique case (ph)
					5'd1: m = mw(OP_SDA_LOW, 5'd0);
					5'd2: m = mw(OP_FULL, 5'd0);
					5'd3: m = mw(OP_SCL_REL, 5'd0);
					5'd4: m = mw(OP_FULL, 5'd0);
					5'd5: m = mw(OP_SDA_REL, 5'd0);
					5'd6: m = mw(OP_FULL, 5'd0);
					default: m = mw(OP_END, 5'd0);
				endcase
			end
			PROG_WRITE: begin
				unique case (ph)
					5'd1: m = mw(OP_COUNT, 5'(BYTE_BITS));
					5'd2: m = mw(OP_SCL_LOW, 5'd0);
					5'd3: m = mw(OP_HALF, 5'd0);
					5'd4: m = mw(OP_SDA_BIT, 5'd0);
					5'd5: m = mw(OP_HALF, 5'd0);
					5'd6: m = mw(OP_SCL_REL, 5'd0);
					5'd7: m = mw(OP_FULL, 5'd0);
					5'd8: m = mw(OP_SHIFT, 5'd0);
					5'd9: m = mw(OP_LOOP, 5'd2);
					5'd10: m = mw(OP_SCL_LOW, 5'd0);
					5'd11: m = mw(OP_HALF, 5'd0);
					5'd12: m = mw(OP_SDA_REL, 5'd0);
					5'd13: m = mw(OP_HALF, 5'd0);
					5'd14: m = mw(OP_SCL_REL, 5'd0);
					5'd15: m = mw(OP_HALF, 5'd0);
					5'd16: m = mw(OP_ACK_IN, 5'd0);
					5'd17: m = mw(OP_HALF, 5'd0);
					5'd18: m = mw(OP_SCL_LOW, 5'd0);
					default: m = mw(OP_END, 5'd0);
				endcase
			end
			PROG_READ: begin
				unique case (ph)
					5'd1: m = mw(OP_SDA_REL, 5'd0);
					5'd2: m = mw(OP_HALF, 5'd0);
					5'd3: m = mw(OP_HALF, 5'd0);
					5'd4: m = mw(OP_SCL_REL, 5'd0);
					5'd5: m = mw(OP_HALF, 5'd0);
					5'd6: m = mw(OP_BIT_IN, 5'd0);
					5'd7: m = mw(OP_HALF, 5'd0);
					5'd8: m = mw(OP_SCL_LOW, 5'd0);
					5'd9: m = mw(OP_HALF, 5'd0);
					5'd10: m = mw(OP_LOOP, 5'd3);
					5'd11: m = mw(OP_SDA_ACK, 5'd0);
					5'd12: m = mw(OP_HALF, 5'd0);
					5'd13: m = mw(OP_SCL_REL, 5'd0);
					5'd14: m = mw(OP_FULL, 5'd0);
					5'd15: m = mw(OP_SCL_LOW, 5'd0);
					5'd16: m = mw(OP_SDA_REL, 5'd0);
					5'd17: m = mw(OP_RX_OUT, 5'd0);
					default: m = mw(OP_END, 5'd0);
				endcase
			end
			default: begin
				unique case (ph)
					5'd1: m = mw(OP_SDA_REL, 5'd0);
					5'd2: m = mw(OP_SCL_REL, 5'd0);
					5'd3: m = mw(OP_COUNT, 5'(RECOVER_PULSES));
					5'd4: m = mw(OP_FULL, 5'd0);
					5'd5: m = mw(OP_SCL_LOW, 5'd0);
					5'd6: m = mw(OP_FULL, 5'd0);
					5'd7: m = mw(OP_SCL_REL, 5'd0);
					5'd8: m = mw(OP_LOOP, 5'd4);
					5'd9: m = mw(OP_SDA_LOW, 5'd0);
					5'd10: m = mw(OP_FULL, 5'd0);
					5'd11: m = mw(OP_SCL_REL, 5'd0);
					5'd12: m = mw(OP_FULL, 5'd0);
					5'd13: m = mw(OP_SDA_REL, 5'd0);
					5'd14: m = mw(OP_FULL, 5'd0);
					default: m = mw(OP_END, 5'd0);
				endcase
			end
		endcase
		return m;
	endfunction

endpackage

[rtl/core/i2cm_core.sv]
// Bus sequencer of the I2C bus master: state registers and the per-tick
// micro-step chain. Depends on i2cm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cm_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  i2cm_pkg::tick_t      tick,
	input  logic [15:0]          delay_ticks,
	output i2cm_pkg::res_t       res_nx
);

	i2cm_pkg::phase_t       phase_q;
	logic [2:0]             op_q;
	logic [3:0]             bit_q;
	logic [7:0]             shift_q;
	logic [COUNT_WIDTH-1:0] wait_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   ack_q;
	logic [7:0]             rx_q;

	i2cm_pkg::phase_t       ph;
	i2cm_pkg::phase_t       nxt;
	logic [2:0]             op_a;
	logic [3:0]             bits;
	logic [7:0]             shf;
	logic [COUNT_WIDTH-1:0] wc;
	logic [COUNT_WIDTH-1:0] wc_base;
	logic [COUNT_WIDTH-1:0] load;
	logic                   scl;
	logic                   sda;
	logic                   ack;
	logic [7:0]             rx;
	logic                   run;
	logic                   done;
	logic                   hit_full;
	logic                   hit_half;
	logic                   hit_end;
	logic [2:0]             prog;
	i2cm_pkg::micro_t       m;
	logic [15:0]            sel;
	logic [31:0]            sel_w;

	always_comb begin
		ph       = phase_q;
		op_a     = op_q;
		bits     = bit_q;
		shf      = shift_q;
		wc       = wait_q;
		scl      = scl_q;
		sda      = sda_q;
		ack      = ack_q;
		rx       = rx_q;
		done     = 1'b0;
		hit_full = 1'b0;
		hit_half = 1'b0;
		hit_end  = 1'b0;
		m        = i2cm_pkg::mw(i2cm_pkg::OP_END, 5'd0);
		nxt      = phase_q;
		wc_base  = wait_q;
		if (phase_q == i2cm_pkg::PH_IDLE && tick.func >= i2cm_pkg::FUNC_START &&
				tick.func <= i2cm_pkg::FUNC_RECOVER) begin
			op_a = (tick.func == i2cm_pkg::FUNC_READ && tick.send_ack) ?
				i2cm_pkg::FUNC_READ_ACK : tick.func;
			shf  = (tick.func == i2cm_pkg::FUNC_WRITE) ? tick.tx_byte : 8'd0;
			bits = 4'd0;
			wc   = '0;
			ph   = i2cm_pkg::PH_FIRST;
		end
		run  = (ph != i2cm_pkg::PH_IDLE);
		prog = i2cm_pkg::prog_of(op_a);
		for (int i = 0; i < i2cm_pkg::CHAIN_STEPS; i++) begin
			if (run) begin
				m   = i2cm_pkg::micro_word(prog, ph);
				nxt = i2cm_pkg::phase_t'(ph + 1'b1);
				unique case (m.op) inside
					i2cm_pkg::OP_SDA_REL: sda = 1'b0;
					i2cm_pkg::OP_SDA_LOW: sda = 1'b1;
					i2cm_pkg::OP_SDA_BIT: sda = !shf[i2cm_pkg::TX_MSB];
					i2cm_pkg::OP_SDA_ACK: sda = (op_a == i2cm_pkg::FUNC_READ_ACK);
					i2cm_pkg::OP_SCL_LOW: scl = 1'b1;
					i2cm_pkg::OP_SCL_REL: begin
						scl = 1'b0;
						if (!tick.scl_in) begin
							run = 1'b0;
							nxt = ph;
						end
					end
					i2cm_pkg::OP_FULL, i2cm_pkg::OP_HALF: begin
						hit_full = (m.op == i2cm_pkg::OP_FULL);
						hit_half = (m.op == i2cm_pkg::OP_HALF);
						run      = 1'b0;
						nxt      = ph;
					end
					i2cm_pkg::OP_ACK_IN: ack = tick.sda_in;
					i2cm_pkg::OP_BIT_IN: shf = {shf[6:0], tick.sda_in};
					i2cm_pkg::OP_SHIFT: shf = {shf[6:0], 1'b0};
					i2cm_pkg::OP_COUNT: bits = m.arg[3:0];
					i2cm_pkg::OP_LOOP: begin
						if (bits > 4'd1) begin
							bits = bits - 4'd1;
							nxt  = m.arg;
						end else begin
							bits = 4'd0;
						end
					end
					i2cm_pkg::OP_RX_OUT: rx = shf;
					default: begin
						hit_end = 1'b1;
						run     = 1'b0;
						nxt     = ph;
					end
				endcase
				ph = nxt;
			end
		end
		sel   = hit_full ? delay_ticks : {1'b0, delay_ticks[15:1]};
		sel_w = 32'(sel);
		if ((sel_w >> COUNT_WIDTH) != 32'd0) begin
			load = '1;
		end else if (sel_w == 32'd0) begin
			load = COUNT_WIDTH'(1);
		end else begin
			load = COUNT_WIDTH'(sel_w);
		end
		if (hit_full || hit_half) begin
			wc_base = (wc == '0) ? load : wc;
			wc      = wc_base - COUNT_WIDTH'(1);
			if (wc == '0) begin
				ph = i2cm_pkg::phase_t'(ph + 1'b1);
			end
		end else if (hit_end) begin
			ph   = i2cm_pkg::PH_IDLE;
			done = 1'b1;
		end
		res_nx.scl_low  = scl;
		res_nx.sda_low  = sda;
		res_nx.busy_res = (ph != i2cm_pkg::PH_IDLE);
		res_nx.done_res = done;
		res_nx.rx_byte  = rx;
		res_nx.ack_seen = ack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PH_IDLE;
			op_q    <= i2cm_pkg::FUNC_NONE;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			wait_q  <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			ack_q   <= 1'b0;
			rx_q    <= 8'd0;
		end else if (en) begin
			phase_q <= ph;
			op_q    <= op_a;
			bit_q   <= bits;
			shift_q <= shf;
			wait_q  <= wc;
			scl_q   <= scl;
			sda_q   <= sda;
			ack_q   <= ack;
			rx_q    <= rx;
		end
	end

	`ASSERT_ALWAYS(a_done_goes_idle, clk, arst_n, en && res_nx.done_res |=> phase_q == i2cm_pkg::PH_IDLE, "finished command did not return to idle")
	`ASSERT_ALWAYS(a_idle_wait_clear, clk, arst_n, phase_q == i2cm_pkg::PH_IDLE |-> wait_q == '0, "delay counter left running while idle")
	`ASSERT_NEVER(a_bit_count_range, clk, arst_n, bit_q > i2cm_pkg::RECOVER_PULSES, "bit counter out of range")

endmodule

[rtl/core/i2c_bus_master_top.sv]
// Top level of the I2C bus master: tick and result channels, input and
// result registers, and the APB register. Depends on i2cm_pkg and i2cm_core.
//
// Each word on the tick channel is one timing tick of the bus: a command
// (taken only while idle), the byte to send, the ACK choice for reads and
// the sensed SCL and SDA levels. Every tick yields exactly one result word:
// the open-drain pull-low drives, busy and done flags, the last received
// byte and the ACK bit sampled after the last write.
// A tick is accepted when tick_valid is high and tick_stall is low; a result
// is taken when res_valid is high and res_stall is low.
// An accepted tick passes through the input register, then the result
// register. One tick is accepted every cycle while res_stall is low; the
// cycle is set by the up to four micro-steps the sequencer resolves per tick.
// While res_stall holds a waiting result, one further tick is still taken
// into the input register; tick_stall rises only when both are full.
// Reset clears the sequencer to idle with both lines released and sets the
// delay register to ten ticks. delay_ticks lies at byte address 0 and is to
// be written only while no tick is in flight.
module i2c_bus_master_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick_valid,
	output logic        tick_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        scl_in,
	input  logic        sda_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl_low,
	output logic        sda_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_seen,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic            valid_s1;
	i2cm_pkg::tick_t tick_s1;
	logic            res_valid_q;
	i2cm_pkg::res_t  res_q;
	i2cm_pkg::res_t  res_nx;
	logic            blocked;
	logic            adv;
	logic            take;
	logic [15:0]     delay_ticks_q;
	logic            reg_idx;

	assign blocked    = res_valid_q && res_stall;
	assign tick_stall = valid_s1 && blocked;
	assign take       = tick_valid && !tick_stall;
	assign adv        = valid_s1 && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1.func     <= func;
			tick_s1.tx_byte  <= tx_byte;
			tick_s1.send_ack <= send_ack;
			tick_s1.scl_in   <= scl_in;
			tick_s1.sda_in   <= sda_in;
		end
	end

	i2cm_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.tick       (tick_s1),
		.delay_ticks(delay_ticks_q),
		.res_nx     (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign scl_low   = res_q.scl_low;
	assign sda_low   = res_q.sda_low;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign rx_byte   = res_q.rx_byte;
	assign ack_seen  = res_q.ack_seen;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= i2cm_pkg::DELAY_RESET;
		end else if (psel && penable && pwrite && pready &&
				reg_idx == i2cm_pkg::REG_DELAY_TICKS) begin
			delay_ticks_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (reg_idx == i2cm_pkg::REG_DELAY_TICKS) begin
			prdata = {16'd0, delay_ticks_q};
		end else begin
			prdata = 32'd0;
		end
	end

endmodule

[test/i2c_bus_master_top_tb.sv]
// Self-checking testbench for i2c_bus_master_top: drives bus ticks and APB
// writes, predicts every result word and checks it. Depends on i2cm_pkg and i2c_bus_master_top.
`timescale 1ns / 1ps

module i2c_bus_master_top_tb;

	localparam int         IDLE_LIMIT  = 5000;
	localparam int         CHAIN_GUARD = 40;
	localparam int         TOTAL_TICKS = 1700;
	localparam logic [2:0] DELAY_ADDR  = 3'({i2cm_pkg::REG_DELAY_TICKS, 2'b00});
	localparam logic [2:0] FUNC_BAD_LO = 3'd6;
	localparam logic [2:0] FUNC_BAD_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	logic [2:0]  func = i2cm_pkg::FUNC_NONE;
	logic [7:0]  tx_byte = 8'd0;
	logic        send_ack = 1'b0;
	logic        scl_in = 1'b1;
	logic        sda_in = 1'b1;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        scl_low;
	logic        sda_low;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        ack_seen;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	i2c_bus_master_top dut (
		.clk(clk), .arst_n(arst_n),
		.tick_valid(tick_valid), .tick_stall(tick_stall),
		.func(func), .tx_byte(tx_byte), .send_ack(send_ack),
		.scl_in(scl_in), .sda_in(sda_in),
		.res_valid(res_valid), .res_stall(res_stall),
		.scl_low(scl_low), .sda_low(sda_low), .busy_res(busy_res),
		.done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted sequencer state, updated once per accepted word.
	logic [4:0]  seq_phase = i2cm_pkg::PH_IDLE;
	logic [2:0]  seq_op = i2cm_pkg::FUNC_NONE;
	logic [3:0]  seq_bits = 4'd0;
	logic [7:0]  seq_shift = 8'd0;
	logic [15:0] seq_count = 16'd0;
	logic        seq_scl = 1'b0;
	logic        seq_sda = 1'b0;
	logic        seq_ack = 1'b0;
	logic [7:0]  seq_rx = 8'd0;
	logic [15:0] seq_delay = i2cm_pkg::DELAY_RESET;

	i2cm_pkg::res_t expected_bus_words[$];
	i2cm_pkg::res_t oldest_word;
	int   errors = 0;
	int   ticks_sent = 0;
	int   results_checked = 0;
	int   delay_settings = 0;
	int   quiet_cycles = 0;
	int   stall_left = 0;
	int   stretch_left = 0;
	bit   res_calm = 1'b0;
	bit   tick_gaps = 1'b0;
	bit   busy_noise = 1'b0;
	bit   stretch_on = 1'b0;

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [8:0] program_step(logic [2:0] cmd, logic [4:0] ph);
		logic [3:0] code;
		logic [4:0] arg;
		code = i2cm_pkg::OP_END;
		arg = 5'd0;
		case (cmd) inside
			i2cm_pkg::FUNC_START: begin
				case (ph)
					5'd1: code = i2cm_pkg::OP_SDA_REL;
					5'd2: code = i2cm_pkg::OP_SCL_REL;
					5'd3: code = i2cm_pkg::OP_FULL;
					5'd4: code = i2cm_pkg::OP_SDA_LOW;
					5'd5: code = i2cm_pkg::OP_FULL;
					5'd6: code = i2cm_pkg::OP_SCL_LOW;
					default: code = i2cm_pkg::OP_END;
				endcase
			end
			i2cm_pkg::FUNC_STOP: begin
				case (ph)
					5'd1: code = i2cm_pkg::OP_SDA_LOW;
					5'd2: code = i2cm_pkg::OP_FULL;
					5'd3: code = i2cm_pkg::OP_SCL_REL;
					5'd4: code = i2cm_pkg::OP_FULL;
					5'd5: code = i2cm_pkg::OP_SDA_REL;
					5'd6: code = i2cm_pkg::OP_FULL;
					default: code = i2cm_pkg::OP_END;
				endcase
			end
			i2cm_pkg::FUNC_WRITE: begin
				case (ph)
					5'd1: begin
						code = i2cm_pkg::OP_COUNT;
						arg = 5'(i2cm_pkg::BYTE_BITS);
					end
					5'd2: code = i2cm_pkg::OP_SCL_LOW;
					5'd3: code = i2cm_pkg::OP_HALF;
					5'd4: code = i2cm_pkg::OP_SDA_BIT;
					5'd5: code = i2cm_pkg::OP_HALF;
					5'd6: code = i2cm_pkg::OP_SCL_REL;
					5'd7: code = i2cm_pkg::OP_FULL;
					5'd8: code = i2cm_pkg::OP_SHIFT;
					5'd9: begin code = i2cm_pkg::OP_LOOP; arg = 5'd2; end
					5'd10: code = i2cm_pkg::OP_SCL_LOW;
					5'd11: code = i2cm_pkg::OP_HALF;
					5'd12: code = i2cm_pkg::OP_SDA_REL;
					5'd13: code = i2cm_pkg::OP_HALF;
					5'd14: code = i2cm_pkg::OP_SCL_REL;
					5'd15: code = i2cm_pkg::OP_HALF;
					5'd16: code = i2cm_pkg::OP_ACK_IN;
					5'd17: code = i2cm_pkg::OP_HALF;
					5'd18: code = i2cm_pkg::OP_SCL_LOW;
					default: code = i2cm_pkg::OP_END;
				endcase
			end
			i2cm_pkg::FUNC_READ, i2cm_pkg::FUNC_READ_ACK: begin
				case (ph)
					5'd1: code = i2cm_pkg::OP_SDA_REL;
					5'd2: code = i2cm_pkg::OP_HALF;
					5'd3: code = i2cm_pkg::OP_HALF;
					5'd4: code = i2cm_pkg::OP_SCL_REL;
					5'd5: code = i2cm_pkg::OP_HALF;
					5'd6: code = i2cm_pkg::OP_BIT_IN;
					5'd7: code = i2cm_pkg::OP_HALF;
					5'd8: code = i2cm_pkg::OP_SCL_LOW;
					5'd9: code = i2cm_pkg::OP_HALF;
					5'd10: begin code = i2cm_pkg::OP_LOOP; arg = 5'd3; end
					5'd11: code = i2cm_pkg::OP_SDA_ACK;
					5'd12: code = i2cm_pkg::OP_HALF;
					5'd13: code = i2cm_pkg::OP_SCL_REL;
					5'd14: code = i2cm_pkg::OP_FULL;
					5'd15: code = i2cm_pkg::OP_SCL_LOW;
					5'd16: code = i2cm_pkg::OP_SDA_REL;
					5'd17: code = i2cm_pkg::OP_RX_OUT;
					default: code = i2cm_pkg::OP_END;
				endcase
			end
			default: begin
				case (ph)
					5'd1: code = i2cm_pkg::OP_SDA_REL;
					5'd2: code = i2cm_pkg::OP_SCL_REL;
					5'd3: begin
						code = i2cm_pkg::OP_COUNT;
						arg = 5'(i2cm_pkg::RECOVER_PULSES);
					end
					5'd4: code = i2cm_pkg::OP_FULL;
					5'd5: code = i2cm_pkg::OP_SCL_LOW;
					5'd6: code = i2cm_pkg::OP_FULL;
					5'd7: code = i2cm_pkg::OP_SCL_REL;
					5'd8: begin code = i2cm_pkg::OP_LOOP; arg = 5'd4; end
					5'd9: code = i2cm_pkg::OP_SDA_LOW;
					5'd10: code = i2cm_pkg::OP_FULL;
					5'd11: code = i2cm_pkg::OP_SCL_REL;
					5'd12: code = i2cm_pkg::OP_FULL;
					5'd13: code = i2cm_pkg::OP_SDA_REL;
					5'd14: code = i2cm_pkg::OP_FULL;
					default: code = i2cm_pkg::OP_END;
				endcase
			end
		endcase
		return {code, arg};
	endfunction

	task automatic advance_bus_sequencer(input i2cm_pkg::tick_t t, output i2cm_pkg::res_t r);
		logic [8:0]  entry;
		logic [3:0]  code;
		logic [4:0]  arg;
		logic [4:0]  next_phase;
		logic [15:0] load;
		logic        finished;
		logic        halted;
		finished = 1'b0;
		halted = 1'b0;
		if (seq_phase == i2cm_pkg::PH_IDLE && t.func >= i2cm_pkg::FUNC_START &&
				t.func <= i2cm_pkg::FUNC_RECOVER) begin
			seq_op = (t.func == i2cm_pkg::FUNC_READ && t.send_ack) ?
				i2cm_pkg::FUNC_READ_ACK : t.func;
			seq_shift = (t.func == i2cm_pkg::FUNC_WRITE) ? t.tx_byte : 8'd0;
			seq_bits = 4'd0;
			seq_count = 16'd0;
			seq_phase = i2cm_pkg::PH_FIRST;
		end
		if (seq_phase != i2cm_pkg::PH_IDLE) begin
			for (int g = 0; g < CHAIN_GUARD && !halted; g++) begin
				entry = program_step(seq_op, seq_phase);
				code = entry[8:5];
				arg = entry[4:0];
				next_phase = seq_phase + 5'd1;
				case (code) inside
					i2cm_pkg::OP_SDA_REL: seq_sda = 1'b0;
					i2cm_pkg::OP_SDA_LOW: seq_sda = 1'b1;
					i2cm_pkg::OP_SDA_BIT: seq_sda = !seq_shift[7];
					i2cm_pkg::OP_SDA_ACK: seq_sda = (seq_op == i2cm_pkg::FUNC_READ_ACK);
					i2cm_pkg::OP_SCL_LOW: seq_scl = 1'b1;
					i2cm_pkg::OP_SCL_REL: begin
						seq_scl = 1'b0;
						if (!t.scl_in) begin
							next_phase = seq_phase;
							halted = 1'b1;
						end
					end
					i2cm_pkg::OP_FULL, i2cm_pkg::OP_HALF: begin
						if (seq_count == 16'd0) begin
							load = (code == i2cm_pkg::OP_FULL) ? seq_delay : (seq_delay >> 1);
							seq_count = (load == 16'd0) ? 16'd1 : load;
						end
						seq_count = seq_count - 16'd1;
						if (seq_count != 16'd0)
							next_phase = seq_phase;
						halted = 1'b1;
					end
					i2cm_pkg::OP_ACK_IN: seq_ack = t.sda_in;
					i2cm_pkg::OP_BIT_IN: seq_shift = {seq_shift[6:0], t.sda_in};
					i2cm_pkg::OP_SHIFT: seq_shift = {seq_shift[6:0], 1'b0};
					i2cm_pkg::OP_COUNT: seq_bits = arg[3:0];
					i2cm_pkg::OP_LOOP: begin
						if (seq_bits > 4'd1) begin
							seq_bits = seq_bits - 4'd1;
							next_phase = arg;
						end else begin
							seq_bits = 4'd0;
						end
					end
					i2cm_pkg::OP_RX_OUT: seq_rx = seq_shift;
					default: begin
						next_phase = i2cm_pkg::PH_IDLE;
						finished = 1'b1;
						halted = 1'b1;
					end
				endcase
				seq_phase = next_phase;
			end
		end
		r.scl_low = seq_scl;
		r.sda_low = seq_sda;
		r.busy_res = (seq_phase != i2cm_pkg::PH_IDLE);
		r.done_res = finished;
		r.rx_byte = seq_rx;
		r.ack_seen = seq_ack;
	endtask

	task automatic bus_levels(output logic s, output logic d);
		if (stretch_left == 0 && stretch_on && $urandom_range(0, 19) == 0)
			stretch_left = gap_len();
		if (stretch_left > 0) begin
			stretch_left--;
			s = 1'b0;
		end else begin
			s = 1'b1;
		end
		d = 1'($urandom_range(0, 1));
	endtask

	task automatic send_tick(input i2cm_pkg::tick_t t);
		i2cm_pkg::res_t r;
		tick_valid <= 1'b1;
		func <= t.func;
		tx_byte <= t.tx_byte;
		send_ack <= t.send_ack;
		scl_in <= t.scl_in;
		sda_in <= t.sda_in;
		do @(posedge clk); while (tick_stall);
		advance_bus_sequencer(t, r);
		expected_bus_words.push_back(r);
		ticks_sent++;
		if (tick_gaps && $urandom_range(0, 4) == 0) begin
			tick_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic run_command(input logic [2:0] f, input logic [7:0] b, input logic a);
		i2cm_pkg::tick_t t;
		t.func = f;
		t.tx_byte = b;
		t.send_ack = a;
		bus_levels(t.scl_in, t.sda_in);
		send_tick(t);
		while (seq_phase != i2cm_pkg::PH_IDLE) begin
			t.func = (busy_noise && $urandom_range(0, 5) == 0) ?
				3'($urandom_range(0, 7)) : i2cm_pkg::FUNC_NONE;
			t.tx_byte = 8'($urandom);
			t.send_ack = 1'($urandom);
			bus_levels(t.scl_in, t.sda_in);
			send_tick(t);
		end
	endtask

	task automatic settle();
		tick_valid <= 1'b0;
		while (expected_bus_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_delay(input logic [15:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DELAY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== want) begin
			$error("delay_ticks readback: expected %0d, got %0d", want, prdata[15:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_delay(input logic [15:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DELAY_ADDR;
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seq_delay = value;
		delay_settings++;
		@(posedge clk);
		read_delay(value);
	endtask

	task automatic test_register_reset();
		read_delay(i2cm_pkg::DELAY_RESET);
		write_delay(16'd2);
	endtask

	task automatic test_directed_commands();
		run_command(i2cm_pkg::FUNC_NONE, 8'h00, 1'b0);
		run_command(i2cm_pkg::FUNC_START, 8'h00, 1'b0);
		run_command(i2cm_pkg::FUNC_WRITE, 8'h00, 1'b0);
		run_command(i2cm_pkg::FUNC_WRITE, 8'hFF, 1'b1);
		run_command(i2cm_pkg::FUNC_READ, 8'h00, 1'b1);
		run_command(i2cm_pkg::FUNC_READ, 8'hFF, 1'b0);
		run_command(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0);
		run_command(FUNC_BAD_LO, 8'h5A, 1'b1);
		run_command(FUNC_BAD_HI, 8'hA5, 1'b0);
		run_command(i2cm_pkg::FUNC_RECOVER, 8'h00, 1'b0);
		busy_noise = 1'b1;
		tick_gaps = 1'b1;
		run_command(i2cm_pkg::FUNC_WRITE, 8'hA5, 1'b0);
		run_command(i2cm_pkg::FUNC_READ, 8'h3C, 1'b1);
		stretch_left = 25;
		run_command(i2cm_pkg::FUNC_START, 8'h00, 1'b0);
		stretch_left = 12;
		run_command(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0);
		busy_noise = 1'b0;
		tick_gaps = 1'b0;
	endtask

	task automatic test_short_delays();
		write_delay(16'd1);
		run_command(i2cm_pkg::FUNC_START, 8'h00, 1'b0);
		run_command(i2cm_pkg::FUNC_WRITE, 8'($urandom), 1'b0);
		run_command(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0);
		write_delay(16'd0);
		run_command(i2cm_pkg::FUNC_START, 8'h00, 1'b0);
		run_command(i2cm_pkg::FUNC_READ, 8'h00, 1'b1);
		run_command(i2cm_pkg::FUNC_RECOVER, 8'h00, 1'b0);
	endtask

	task automatic test_reset_delay_value();
		write_delay(i2cm_pkg::DELAY_RESET);
		tick_gaps = 1'b1;
		run_command(i2cm_pkg::FUNC_WRITE, 8'($urandom), 1'b0);
		run_command(i2cm_pkg::FUNC_READ, 8'h00, 1'b0);
		tick_gaps = 1'b0;
	endtask

	task automatic test_longest_delay();
		write_delay(16'hFFFF);
	endtask

	task automatic test_random_traffic();
		int kind;
		while (ticks_sent < TOTAL_TICKS) begin
			write_delay(($urandom_range(0, 3) == 0) ? 16'($urandom_range(6, 12)) :
				16'($urandom_range(2, 5)));
			repeat ($urandom_range(2, 4)) begin
				if (ticks_sent < TOTAL_TICKS) begin
					tick_gaps = ($urandom_range(0, 2) != 0);
					busy_noise = 1'($urandom_range(0, 1));
					stretch_on = 1'($urandom_range(0, 1));
					kind = $urandom_range(0, 9);
					if (kind == 0) begin
						run_command(i2cm_pkg::FUNC_RECOVER, 8'($urandom), 1'($urandom));
					end else if (kind == 1) begin
						repeat ($urandom_range(1, 4))
							run_command(3'($urandom_range(0, 7)), 8'($urandom),
								1'($urandom));
					end else begin
						run_command(i2cm_pkg::FUNC_START, 8'($urandom), 1'($urandom));
						run_command(i2cm_pkg::FUNC_WRITE, 8'($urandom), 1'($urandom));
						repeat ($urandom_range(0, 2))
							run_command(i2cm_pkg::FUNC_WRITE, 8'($urandom), 1'($urandom));
						repeat ($urandom_range(0, 2))
							run_command(i2cm_pkg::FUNC_READ, 8'($urandom), 1'($urandom));
						run_command(i2cm_pkg::FUNC_STOP, 8'($urandom), 1'($urandom));
					end
				end
			end
		end
		tick_gaps = 1'b0;
		stretch_on = 1'b0;
		busy_noise = 1'b0;
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 249) == 0)
			res_calm = !res_calm;
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if (!res_calm && $urandom_range(0, 4) == 0) begin
			stall_left = gap_len() - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_bus_words.size() == 0) begin
				$error("result word arrived with no expectation waiting");
				errors++;
			end else begin
				oldest_word = expected_bus_words.pop_front();
				check_field("scl_low", 8'(oldest_word.scl_low), 8'(scl_low));
				check_field("sda_low", 8'(oldest_word.sda_low), 8'(sda_low));
				check_field("busy_res", 8'(oldest_word.busy_res), 8'(busy_res));
				check_field("done_res", 8'(oldest_word.done_res), 8'(done_res));
				check_field("rx_byte", oldest_word.rx_byte, rx_byte);
				check_field("ack_seen", 8'(oldest_word.ack_seen), 8'(ack_seen));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || psel || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timed out after %0d cycles without a handshake.", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_commands();
		test_short_delays();
		test_reset_delay_value();
		test_longest_delay();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		if (expected_bus_words.size() != 0) begin
			$error("%0d expected result words never arrived", expected_bus_words.size());
			errors++;
		end
		$display("Checked %0d result words from %0d ticks over %0d delay settings,",
			results_checked, ticks_sent, delay_settings);
		$display("with clock stretching, commands while busy and idling on both channels.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
